// ----- sv/morse_character_encoder_macros.svh -----
// Assertion macros for the RTL of the Morse character encoder.
`ifndef MORSE_CHARACTER_ENCODER_MACROS_SVH
`define MORSE_CHARACTER_ENCODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define MCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("morse encoder check failed");
// Next-cycle implication, disabled while reset is asserted.
`define MCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("morse encoder check failed");
`else
`define MCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/mce_pkg.sv -----
`default_nettype none

package mce_pkg;

  // Segment durations in time units.
  localparam logic [2:0] UNITS_DOT       = 3'd1;
  localparam logic [2:0] UNITS_DASH      = 3'd3;
  localparam logic [2:0] UNITS_ELEM_GAP  = 3'd1;
  localparam logic [2:0] UNITS_CHAR_GAP  = 3'd3;
  localparam logic [2:0] UNITS_WORD_GAP  = 3'd7;

  localparam int unsigned MAX_ELEMS = 8;

  // One character's code: elements are sent from dashes[7] downward,
  // a set bit is a dash.
  typedef struct packed {
    logic       is_space;
    logic [3:0] len;
    logic [7:0] dashes;
  } pat_t;

  // Build a code from a right-aligned element string of the given length.
  function automatic pat_t mk_pat(input logic [3:0] len, input logic [7:0] bits);
    pat_t p;
    p.is_space = 1'b0;
    p.len      = len;
    p.dashes   = bits << (4'd8 - len);
    return p;
  endfunction

  function automatic pat_t morse_lookup(input logic [7:0] ch);
    pat_t p;
    p = mk_pat(4'd8, 8'b0000_0000);
    unique case (ch) inside
      " ": begin
        p.is_space = 1'b1;
        p.len      = 4'd1;
        p.dashes   = 8'b0;
      end
      "A", "a": p = mk_pat(4'd2, 8'b01);
      "B", "b": p = mk_pat(4'd4, 8'b1000);
      "C", "c": p = mk_pat(4'd4, 8'b1010);
      "D", "d": p = mk_pat(4'd3, 8'b100);
      "E", "e": p = mk_pat(4'd1, 8'b0);
      "F", "f": p = mk_pat(4'd4, 8'b0010);
      "G", "g": p = mk_pat(4'd3, 8'b110);
      "H", "h": p = mk_pat(4'd4, 8'b0000);
      "I", "i": p = mk_pat(4'd2, 8'b00);
      "J", "j": p = mk_pat(4'd4, 8'b0111);
      "K", "k": p = mk_pat(4'd3, 8'b101);
      "L", "l": p = mk_pat(4'd4, 8'b0100);
      "M", "m": p = mk_pat(4'd2, 8'b11);
      "N", "n": p = mk_pat(4'd2, 8'b10);
      "O", "o": p = mk_pat(4'd3, 8'b111);
      "P", "p": p = mk_pat(4'd4, 8'b0110);
      "Q", "q": p = mk_pat(4'd4, 8'b1101);
      "R", "r": p = mk_pat(4'd3, 8'b010);
      "S", "s": p = mk_pat(4'd3, 8'b000);
      "T", "t": p = mk_pat(4'd1, 8'b1);
      "U", "u": p = mk_pat(4'd3, 8'b001);
      "V", "v": p = mk_pat(4'd4, 8'b0001);
      "W", "w": p = mk_pat(4'd3, 8'b011);
      "X", "x": p = mk_pat(4'd4, 8'b1001);
      "Y", "y": p = mk_pat(4'd4, 8'b1011);
      "Z", "z": p = mk_pat(4'd4, 8'b1100);
      "0": p = mk_pat(4'd5, 8'b11111);
      "1": p = mk_pat(4'd5, 8'b01111);
      "2": p = mk_pat(4'd5, 8'b00111);
      "3": p = mk_pat(4'd5, 8'b00011);
      "4": p = mk_pat(4'd5, 8'b00001);
      "5": p = mk_pat(4'd5, 8'b00000);
      "6": p = mk_pat(4'd5, 8'b10000);
      "7": p = mk_pat(4'd5, 8'b11000);
      "8": p = mk_pat(4'd5, 8'b11100);
      "9": p = mk_pat(4'd5, 8'b11110);
      ".": p = mk_pat(4'd6, 8'b010101);
      ",": p = mk_pat(4'd6, 8'b110011);
      ":": p = mk_pat(4'd6, 8'b111000);
      "?": p = mk_pat(4'd6, 8'b001100);
      "-": p = mk_pat(4'd6, 8'b100001);
      "/": p = mk_pat(4'd5, 8'b10010);
      "(": p = mk_pat(4'd5, 8'b10110);
      ")": p = mk_pat(4'd6, 8'b101101);
      8'h22: p = mk_pat(4'd6, 8'b010010);
      "=": p = mk_pat(4'd5, 8'b10001);
      "%": p = mk_pat(4'd5, 8'b00010);
      "+": p = mk_pat(4'd5, 8'b01010);
      "}": p = mk_pat(4'd5, 8'b01000);
      ">": p = mk_pat(4'd6, 8'b000101);
      "<": p = mk_pat(4'd5, 8'b10101);
      "@": p = mk_pat(4'd6, 8'b011010);
      // Anything unmapped sends the eight-dot error code.
      default: p = mk_pat(4'd8, 8'b0000_0000);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- sv/morse_character_encoder.sv -----
// Channel  Ports                               Direction  Moves
// in       in_valid in_ready in_character      input      one character code per item
// out      out_valid out_ready out_level       output     one on/off segment per item
//          out_units out_last
//
// A character yields two segments per element (up to 16) and a space yields one.
// The segment counter emits one segment per cycle unless the output stalls; the next
// character is taken in the cycle its final segment moves to the output register.
// The first segment passes from the character register to the output register.
// Reset (rst_n, synchronous) empties both registers. A stalled output holds the
// counter, and the input waits until the held character is finished.
`default_nettype none

`include "morse_character_encoder_macros.svh"

module morse_character_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_character,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_level,
  output logic [2:0]      out_units,
  output logic            out_last
);

  logic            hold_v_r;
  logic [7:0]      char_r;
  logic [3:0]      seg_r;
  logic            out_valid_r;
  logic            out_level_r;
  logic [2:0]      out_units_r;
  logic            out_last_r;

  mce_pkg::pat_t   pat;
  logic [2:0]      elem_idx;
  logic            elem_last;
  logic            elem_dash;
  logic            seg_level;
  logic [2:0]      seg_units;
  logic            seg_final;
  logic            adv;
  logic            in_fire;

  always_comb begin
    pat       = mce_pkg::morse_lookup(char_r);
    elem_idx  = seg_r[3:1];
    elem_last = (elem_idx == 3'(pat.len - 4'd1));
    elem_dash = pat.dashes[3'd7 - elem_idx];
    if (pat.is_space) begin
      seg_level = 1'b0;
      seg_units = mce_pkg::UNITS_WORD_GAP;
      seg_final = 1'b1;
    end else if (!seg_r[0]) begin
      seg_level = 1'b1;
      seg_units = elem_dash ? mce_pkg::UNITS_DASH : mce_pkg::UNITS_DOT;
      seg_final = 1'b0;
    end else begin
      // The gap after the last element is the longer character gap.
      seg_level = 1'b0;
      seg_units = elem_last ? mce_pkg::UNITS_CHAR_GAP : mce_pkg::UNITS_ELEM_GAP;
      seg_final = elem_last;
    end
  end

  assign adv      = hold_v_r && (!out_valid_r || out_ready);
  assign in_ready = !hold_v_r || (adv && seg_final);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      seg_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        hold_v_r <= 1'b1;
        seg_r    <= 4'd0;
      end else if (adv && seg_final) begin
        hold_v_r <= 1'b0;
      end else if (adv) begin
        seg_r <= seg_r + 4'd1;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      char_r <= in_character;
    end
    if (adv) begin
      out_level_r <= seg_level;
      out_units_r <= seg_units;
      out_last_r  <= seg_final;
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_units = out_units_r;
  assign out_last  = out_last_r;

  // The counter never runs past the held character's last element.
  `MCE_ASSERT_IMPL(a_seg_in_range, clk, rst_n, hold_v_r && !pat.is_space,
                   elem_idx <= 3'(pat.len - 4'd1))
  // A freshly taken character starts at its first segment.
  `MCE_ASSERT_NEXT(a_fresh_start, clk, rst_n, in_fire, hold_v_r && seg_r == 4'd0)
  // A character never ends on an on segment.
  `MCE_ASSERT_IMPL(a_last_is_off, clk, rst_n, out_valid_r && out_level_r, !out_last_r)
  // The final segment is always a character or word gap.
  `MCE_ASSERT_IMPL(a_last_units, clk, rst_n, out_valid_r && out_last_r,
                   out_units_r == mce_pkg::UNITS_CHAR_GAP ||
                   out_units_r == mce_pkg::UNITS_WORD_GAP)

endmodule

`default_nettype wire
